@@ rtl/modbus_rtu_response_frame_finder_top_defines.svh @@
// Assertion macros for the Modbus RTU response frame finder.
// Depends on nothing; included by the checker file.
`ifndef MODBUS_RTU_RESPONSE_FRAME_FINDER_TOP_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_FRAME_FINDER_TOP_DEFINES_SVH
// Property that must hold at every clock edge outside reset.
`define MRFF_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define MRFF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/mrff_pkg.sv @@
// Package for the Modbus RTU response frame finder: types, constants, CRC step.
// Depends on nothing.
`default_nettype none
package mrff_pkg;
  localparam int BufDepthDef = 256;
  localparam int ReqDepthDef = 4;
  localparam int MaxResults = 64;
  localparam logic [13:0] IdLow = 14'h1000;
  localparam logic [13:0] IdHigh = 14'h2000;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [7:0] ExcMask = 8'h7F;

  typedef enum logic [1:0] {
    ActRx = 2'd0,
    ActReq = 2'd1,
    ActScan = 2'd2,
    ActClear = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic [7:0] req_address;
    logic [7:0] req_function;
    logic [12:0] req_id;
  } cmd_t;

  typedef struct packed {
    logic [7:0] frame_start;
    logic [8:0] frame_length;
    logic [13:0] frame_id;
    logic matched;
    logic none_found;
    logic overflow;
    logic last;
  } res_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction
endpackage
`default_nettype wire

@@ rtl/modbus_rtu_response_frame_finder_top.sv @@
// Modbus RTU response frame finder: a byte store scanned for CRC-16 framed spans.
// Receive, request and clear transfers pass a two-entry queue and reach the engine the cycle
// after their transfer; the idle engine takes one per cycle. A scan holds the engine through
// each start position and each start and end pair, paced by the single-port byte store read
// once per step, and through the request lookup for each frame found; meanwhile the queue
// fills and stalls the input. One result is held back so that the last one can carry its
// flag, a waiting result stalls the scan, and no command is taken until the final result of
// a scan has been transferred.
// Depends on mrff_pkg, mrff_cmd_fifo and mrff_engine.
`default_nettype none
module modbus_rtu_response_frame_finder_top #(
  parameter int BufDepth = mrff_pkg::BufDepthDef,
  parameter int ReqDepth = mrff_pkg::ReqDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // action[1:0]
  input  wire logic [1:0] s_axis_tuser,
  // data_byte[7:0], req_address[15:8], req_function[23:16], req_id[36:24], zero fill
  input  wire logic [39:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  // frame_start[7:0], frame_length[16:8], frame_id[30:17], matched, none_found, overflow
  output logic [39:0] m_axis_tdata,
  output logic m_axis_tlast
);
  import mrff_pkg::*;
  cmd_t in_cmd, q_cmd;
  res_t res;
  logic q_valid, q_ready;

  assign in_cmd = '{s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                    s_axis_tdata[23:16], s_axis_tdata[36:24]};

  mrff_cmd_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_cmd_i(in_cmd),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_cmd_o(q_cmd)
  );

  mrff_engine #(.BufDepth(BufDepth), .ReqDepth(ReqDepth)) u_engine (
    .clk_i, .rst_ni,
    .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {6'd0, res.overflow, res.none_found, res.matched, res.frame_id,
                         res.frame_length, res.frame_start};
  assign m_axis_tlast = res.last;
endmodule
`default_nettype wire

@@ rtl/mrff_cmd_fifo.sv @@
// Two-entry command queue between the input side and the scan engine.
// Depends on mrff_pkg.
`default_nettype none
module mrff_cmd_fifo (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire mrff_pkg::cmd_t in_cmd_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output mrff_pkg::cmd_t out_cmd_o
);
  import mrff_pkg::*;
  cmd_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;
  assign in_ready_o = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_cmd_o = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_cmd_i;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

@@ rtl/mrff_engine.sv @@
// Back end: byte store, request table and the scanning sequencer.
// Depends on mrff_pkg.
`default_nettype none
module mrff_engine #(
  parameter int BufDepth = mrff_pkg::BufDepthDef,
  parameter int ReqDepth = mrff_pkg::ReqDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  output logic cmd_ready_o,
  input  wire mrff_pkg::cmd_t cmd_i,
  output logic res_valid_o,
  input  wire logic res_ready_i,
  output mrff_pkg::res_t res_o
);
  import mrff_pkg::*;
  localparam int AW = $clog2(BufDepth);
  localparam int CW = AW + 1;
  localparam int RW = (ReqDepth > 1) ? $clog2(ReqDepth) : 1;
  localparam int RCW = $clog2(ReqDepth + 1);

  typedef enum logic [8:0] {
    StIdle = 9'b000000001,
    StRdA  = 9'b000000010,
    StRdB  = 9'b000000100,
    StFeed = 9'b000001000,
    StChk1 = 9'b000010000,
    StChk2 = 9'b000100000,
    StMatch = 9'b001000000,
    StEmit = 9'b010000000,
    StDone = 9'b100000000
  } state_e;

  state_e st_q, st_d;
  logic [7:0] mem [BufDepth];
  logic [7:0] rd_q;
  logic [AW-1:0] raddr;
  logic [7:0] ra_q [ReqDepth];
  logic [7:0] rf_q [ReqDepth];
  logic [12:0] ri_q [ReqDepth];
  logic [CW-1:0] rx_cnt_q;
  logic [RCW-1:0] req_cnt_q;
  logic [13:0] uid_q;
  logic [CW-1:0] s_q, e_q;
  logic [15:0] crc_q;
  logic [7:0] a_q, f_q, lo_q;
  logic [6:0] n_q;
  logic [RW-1:0] mi_q;
  logic [RCW-1:0] mcnt_q;
  logic has_q;
  res_t res_q, pend_q;
  logic res_v_q;
  logic [1:0] sub_q;
  logic [CW-1:0] len;

  assign st_d = st_q;
  assign res_valid_o = res_v_q;
  assign res_o = res_q;
  assign cmd_ready_o = (st_d == StIdle) && !res_v_q;
  assign len = e_q - s_q + CW'(1);

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && cmd_valid_i && cmd_ready_o && cmd_i.action == ActRx &&
        rx_cnt_q < CW'(BufDepth)) begin
      mem[rx_cnt_q[AW-1:0]] <= cmd_i.data_byte;
    end
    rd_q <= mem[raddr];
  end

  // Read address per state; the data is registered into rd_q and returns in the next cycle.
  always_comb begin
    raddr = s_q[AW-1:0];
    unique case (st_q)
      StRdB: raddr = s_q[AW-1:0] + AW'(1);
      StFeed: raddr = (sub_q == 2'd0) ? AW'(e_q - CW'(2)) : AW'(e_q - CW'(1));
      StChk1: raddr = e_q[AW-1:0];
      default: raddr = s_q[AW-1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      rx_cnt_q <= '0;
      req_cnt_q <= '0;
      uid_q <= IdLow;
      res_v_q <= 1'b0;
      has_q <= 1'b0;
      n_q <= '0;
      sub_q <= '0;
      ra_q <= '{default: '0};
      rf_q <= '{default: '0};
      ri_q <= '{default: '0};
      s_q <= '0;
      e_q <= '0;
      crc_q <= '0;
      a_q <= '0;
      f_q <= '0;
      lo_q <= '0;
      mi_q <= '0;
      mcnt_q <= '0;
      res_q <= '0;
      pend_q <= '0;
    end else begin
      if (res_v_q && res_ready_i && st_q != StDone) res_v_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (cmd_valid_i && cmd_ready_o) begin
            unique case (cmd_i.action)
              ActRx: if (rx_cnt_q < CW'(BufDepth)) rx_cnt_q <= rx_cnt_q + CW'(1);
              ActReq: if (req_cnt_q < RCW'(ReqDepth)) begin
                ra_q[req_cnt_q[RW-1:0]] <= cmd_i.req_address;
                rf_q[req_cnt_q[RW-1:0]] <= cmd_i.req_function;
                ri_q[req_cnt_q[RW-1:0]] <= cmd_i.req_id;
                req_cnt_q <= req_cnt_q + RCW'(1);
              end
              ActScan: begin
                s_q <= '0;
                n_q <= '0;
                has_q <= 1'b0;
                st_q <= StRdA;
              end
              default: begin
                rx_cnt_q <= '0;
                req_cnt_q <= '0;
              end
            endcase
          end
        end
        StRdA: begin
          // Starts a new start position: s_q is read this cycle.
          if (s_q + CW'(2) >= rx_cnt_q) begin
            st_q <= StDone;
          end else begin
            st_q <= StRdB;
          end
        end
        StRdB: begin
          a_q <= rd_q;
          e_q <= s_q + CW'(2);
          crc_q <= CrcInit;
          sub_q <= 2'd0;
          st_q <= StFeed;
        end
        StFeed: begin
          // sub 0: capture f on first pass, issue read of e-2; sub 1: feed the CRC, issue e-1.
          if (sub_q == 2'd0) begin
            if (e_q == s_q + CW'(2)) f_q <= rd_q & ExcMask;
            sub_q <= 2'd1;
          end else begin
            crc_q <= crc_feed(crc_q, rd_q);
            sub_q <= 2'd0;
            st_q <= StChk1;
          end
        end
        StChk1: begin
          lo_q <= rd_q;
          st_q <= StChk2;
        end
        StChk2: begin
          if (len >= CW'(4) && lo_q == crc_q[7:0] && rd_q == crc_q[15:8]) begin
            if (n_q == 7'(MaxResults)) begin
              res_q <= '{pend_q.frame_start, pend_q.frame_length, pend_q.frame_id,
                         pend_q.matched, 1'b0, 1'b1, 1'b1};
              has_q <= 1'b0;
              res_v_q <= 1'b1;
              st_q <= StEmit;
              n_q <= 7'(MaxResults + 1);
            end else begin
              mi_q <= '0;
              mcnt_q <= '0;
              st_q <= StMatch;
            end
          end else begin
            st_q <= StEmit;
          end
        end
        StMatch: begin
          if (mcnt_q < req_cnt_q && RCW'(mi_q) == mcnt_q &&
              ra_q[mi_q] == a_q && (rf_q[mi_q] & ExcMask) == f_q) begin
            pend_q <= '{8'(s_q), 9'(len), {1'b0, ri_q[mi_q]}, 1'b1, 1'b0, 1'b0, 1'b0};
            if (has_q) begin
              res_q <= pend_q;
              res_v_q <= 1'b1;
            end
            has_q <= 1'b1;
            n_q <= n_q + 7'd1;
            st_q <= StEmit;
          end else if (mcnt_q + RCW'(1) >= req_cnt_q ||
                       mcnt_q + RCW'(1) >= RCW'(ReqDepth)) begin
            if (uid_q < IdLow || uid_q > IdHigh) begin
              pend_q <= '{8'(s_q), 9'(len), IdLow, 1'b0, 1'b0, 1'b0, 1'b0};
              uid_q <= IdLow + 14'd1;
            end else begin
              pend_q <= '{8'(s_q), 9'(len), uid_q, 1'b0, 1'b0, 1'b0, 1'b0};
              uid_q <= uid_q + 14'd1;
            end
            if (has_q) begin
              res_q <= pend_q;
              res_v_q <= 1'b1;
            end
            has_q <= 1'b1;
            n_q <= n_q + 7'd1;
            st_q <= StEmit;
          end else begin
            mcnt_q <= mcnt_q + RCW'(1);
            mi_q <= mi_q + RW'(1);
          end
        end
        StEmit: begin
          // Wait for the output register, then end an overflowed scan or advance to next end or start.
          if (!res_v_q || res_ready_i) begin
            if (n_q == 7'(MaxResults + 1)) begin
              st_q <= StIdle;
            end else if (e_q + CW'(1) < rx_cnt_q) begin
              e_q <= e_q + CW'(1);
              st_q <= StFeed;
            end else begin
              s_q <= s_q + CW'(1);
              st_q <= StRdA;
            end
          end
        end
        StDone: begin
          if (!res_v_q || res_ready_i) begin
            if (has_q) begin
              res_q <= '{pend_q.frame_start, pend_q.frame_length, pend_q.frame_id,
                         pend_q.matched, 1'b0, 1'b0, 1'b1};
            end else begin
              res_q <= '{8'd0, 9'd0, 14'd0, 1'b0, 1'b1, 1'b0, 1'b1};
            end
            res_v_q <= 1'b1;
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/mrff_checker.sv @@
// Port-level checker for the frame finder, bound to the top level.
// Depends on the assertion macro header.
`default_nettype none
`include "modbus_rtu_response_frame_finder_top_defines.svh"
module mrff_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic m_axis_tlast
);
  logic stall, none_f, ovf_f;
  assign stall = m_axis_tvalid && !m_axis_tready;
  assign none_f = m_axis_tvalid && m_axis_tdata[32];
  assign ovf_f = m_axis_tvalid && m_axis_tdata[33];
  `MRFF_ASSERT(a_hold, clk_i, rst_ni, stall |=> m_axis_tvalid, "result dropped")
  `MRFF_ASSERT(a_none_last, clk_i, rst_ni, none_f |-> m_axis_tlast, "none_found without last")
  `MRFF_ASSERT(a_ovf_last, clk_i, rst_ni, ovf_f |-> m_axis_tlast, "overflow without last")
  `MRFF_ASSERT_NEXT(a_stable, clk_i, rst_ni, stall, $stable(m_axis_tdata), "payload changed")
endmodule
bind modbus_rtu_response_frame_finder_top mrff_checker u_chk (.*);
`default_nettype wire
